[sv/plm_pkg.sv]
// Shared constants and payload types for the piecewise-linear membership block.
// No dependencies; compile this file first.
package plm_pkg;

  localparam int LANE_W             = 16;
  localparam int MAX_LANES          = 8;
  localparam int DEFAULT_MAX_POINTS = 8;
  localparam int CFG_DATA_W         = 64;
  localparam int CFG_INDEX_W        = 3;
  localparam int PCOUNT_W           = 4;
  localparam int SEG_W              = 4;

  // 1.0 in Q1.15, one bit wider than a lane so it compares against raw lanes
  localparam logic [LANE_W:0] ONE_Q15 = 17'h08000;

  typedef logic signed [LANE_W-1:0] sample_t;
  typedef logic        [LANE_W-1:0] degree_t;
  typedef logic        [SEG_W-1:0]  segment_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_X_LOW       = 3'd0,
    CFG_X_HIGH      = 3'd1,
    CFG_Y_LOW       = 3'd2,
    CFG_Y_HIGH      = 3'd3,
    CFG_POINT_COUNT = 3'd4
  } cfg_reg_t;

endpackage

[sv/plm_channels.sv]
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on plm_pkg for the payload types.
interface plm_sample_if;
  import plm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface plm_result_if;
  import plm_pkg::*;
  logic     valid;
  logic     ready;
  degree_t  degree;
  segment_t segment;
  logic     table_invalid;
  modport source (output valid, output degree, output segment, output table_invalid,
                  input ready);
  modport sink   (input valid, input degree, input segment, input table_invalid,
                  output ready);
endinterface

[sv/piecewise_linear_membership.sv]
// Top level: piecewise-linear fuzzy membership evaluator with bit-serial datapath.
// Depends on plm_pkg and on plm_sample_if / plm_result_if from plm_channels.sv.
//
//   Channel   Direction  Handshake          Payload
//   sample    in         valid / ready      sample_in (signed 16)
//   result    out        valid / ready      degree (16), segment (4), table_invalid (1)
//   config    in         cfg_we, no stall   cfg_index (3), cfg_data (64)
//
// One sample at a time. A sample inside the table passes through segment search,
// operand setup, a shift-add multiply and a restoring division (one bit per cycle
// each), and a final add and clamp. Samples at or below the first point, above the
// last point or in a zero-width segment skip the serial unit.
// Synchronous reset clears the table to all zeros with one point in use.
// A finished result sits in the output register; a new sample is taken meanwhile,
// and the block holds its final step while the output register is still full.
module piecewise_linear_membership #(
  parameter int MAX_POINTS = plm_pkg::DEFAULT_MAX_POINTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [plm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [plm_pkg::CFG_DATA_W-1:0]  cfg_data,
  plm_sample_if.sink                      sample,
  plm_result_if.source                    result
);
  import plm_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(LANE_W);
  localparam logic [PCOUNT_W-1:0] MAX_N = PCOUNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LANE_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_FIND, ST_SETUP, ST_MUL, ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_BELOW, MODE_ABOVE, MODE_INSIDE
  } mode_t;

  // Configuration registers
  logic [CFG_DATA_W-1:0] x_low, x_high, y_low, y_high;
  logic [PCOUNT_W-1:0]   point_count;

  // Per-item registers
  state_t               state;
  mode_t                mode;
  sample_t              sample_reg;
  logic [SEG_W-1:0]     seg_reg;
  logic [IDX_W-1:0]     hit_reg;
  logic                 bad_reg;
  logic [LANE_W-1:0]    base;
  logic                 neg;
  logic [LANE_W-1:0]    mcand;
  logic [LANE_W-1:0]    divisor;
  logic [2*LANE_W-1:0]  prod;
  logic [CNT_W-1:0]     cnt;

  // Output register
  logic                 out_valid;
  degree_t              out_degree;
  segment_t             out_segment;
  logic                 out_invalid;

  // Decoded table
  logic [2*CFG_DATA_W-1:0] x_cat, y_cat;
  logic signed [LANE_W-1:0] x_lane [MAX_POINTS];
  logic [LANE_W-1:0]        y_raw  [MAX_POINTS];
  logic [LANE_W-1:0]        y_lane [MAX_POINTS];
  logic [PCOUNT_W-1:0]      n_used;
  logic [IDX_W-1:0]         last_idx;
  logic                     table_bad;

  // Search and select
  logic [MAX_POINTS-1:0]    le;
  logic [IDX_W-1:0]         hit;
  logic [IDX_W-1:0]         hit_m1;
  logic signed [LANE_W-1:0] x0, xk;
  logic [LANE_W-1:0]        y0, yk, y_last;
  logic signed [LANE_W:0]   dx, dy, x_off, dy_mag;

  // Serial steps and final add
  logic [LANE_W:0]          mul_sum;
  logic [LANE_W:0]          div_trial;
  logic                     div_ge;
  logic [LANE_W:0]          div_rem;
  logic signed [LANE_W+1:0] q_signed, r_sum;
  degree_t                  r_clamped;

  // Split the lane words and clamp y for the datapath
  always_comb begin
    x_cat = {x_high, x_low};
    y_cat = {y_high, y_low};
    for (int k = 0; k < MAX_POINTS; k++) begin
      x_lane[k] = x_cat[k*LANE_W +: LANE_W];
      y_raw[k]  = y_cat[k*LANE_W +: LANE_W];
      y_lane[k] = ({1'b0, y_raw[k]} > ONE_Q15) ? ONE_Q15[LANE_W-1:0] : y_raw[k];
    end
  end

  // Points in use, saturated to 1..MAX_POINTS
  always_comb begin
    if (point_count == '0) begin
      n_used = PCOUNT_W'(1);
    end else if (point_count > MAX_N) begin
      n_used = MAX_N;
    end else begin
      n_used = point_count;
    end
    last_idx = IDX_W'(n_used - PCOUNT_W'(1));
  end

  // Table consistency: sorted x and y lanes within 1.0
  always_comb begin
    logic bad;
    bad = 1'b0;
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (PCOUNT_W'(k) < n_used && {1'b0, y_raw[k]} > ONE_Q15) begin
        bad = 1'b1;
      end
    end
    for (int k = 1; k < MAX_POINTS; k++) begin
      if (PCOUNT_W'(k) < n_used && x_lane[k-1] > x_lane[k]) begin
        bad = 1'b1;
      end
    end
    table_bad = (n_used > PCOUNT_W'(1)) && bad;
  end

  // Compare the sample against every breakpoint and take the first segment hit
  always_comb begin
    hit = '0;
    for (int k = 0; k < MAX_POINTS; k++) begin
      le[k] = (sample_reg <= x_lane[k]);
    end
    for (int k = MAX_POINTS - 1; k >= 1; k--) begin
      if (PCOUNT_W'(k) < n_used && le[k]) begin
        hit = IDX_W'(k);
      end
    end
  end

  // Select segment end points and form the differences
  always_comb begin
    hit_m1 = hit_reg - IDX_W'(1);
    x0     = '0;
    xk     = '0;
    y0     = '0;
    yk     = '0;
    y_last = '0;
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (IDX_W'(k) == hit_reg) begin
        xk = x_lane[k];
        yk = y_lane[k];
      end
      if (IDX_W'(k) == hit_m1) begin
        x0 = x_lane[k];
        y0 = y_lane[k];
      end
      if (IDX_W'(k) == last_idx) begin
        y_last = y_lane[k];
      end
    end
    dx     = $signed({xk[LANE_W-1], xk}) - $signed({x0[LANE_W-1], x0});
    x_off  = $signed({sample_reg[LANE_W-1], sample_reg}) - $signed({x0[LANE_W-1], x0});
    dy     = $signed({1'b0, yk}) - $signed({1'b0, y0});
    dy_mag = dy[LANE_W] ? -dy : dy;
  end

  // One shift-add multiply step and one restoring division step
  always_comb begin
    mul_sum   = prod[0] ? ({1'b0, prod[2*LANE_W-1:LANE_W]} + {1'b0, mcand})
                        : {1'b0, prod[2*LANE_W-1:LANE_W]};
    div_trial = {prod[2*LANE_W-1:LANE_W], prod[LANE_W-1]};
    div_ge    = (div_trial >= {1'b0, divisor});
    div_rem   = div_ge ? (div_trial - {1'b0, divisor}) : div_trial;
  end

  // Add the signed quotient to the base and clamp to 0..1.0
  always_comb begin
    q_signed = $signed({2'b00, prod[LANE_W-1:0]});
    if (neg) begin
      q_signed = -q_signed;
    end
    r_sum = $signed({2'b00, base}) + q_signed;
    if (r_sum < 0) begin
      r_clamped = '0;
    end else if (r_sum > $signed({1'b0, ONE_Q15})) begin
      r_clamped = ONE_Q15[LANE_W-1:0];
    end else begin
      r_clamped = r_sum[LANE_W-1:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low       <= '0;
      x_high      <= '0;
      y_low       <= '0;
      y_high      <= '0;
      point_count <= PCOUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_X_LOW:       x_low       <= cfg_data;
        CFG_X_HIGH:      x_high      <= cfg_data;
        CFG_Y_LOW:       y_low       <= cfg_data;
        CFG_Y_HIGH:      y_high      <= cfg_data;
        CFG_POINT_COUNT: point_count <= cfg_data[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, serial datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop the result once the sink takes it; the final step reloads it itself
      if (out_valid && result.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            sample_reg <= sample.sample_in;
            state      <= ST_FIND;
          end
        end
        ST_FIND: begin
          bad_reg <= table_bad;
          hit_reg <= hit;
          if (le[0]) begin
            mode    <= MODE_BELOW;
            seg_reg <= '0;
          end else if (!le[last_idx]) begin
            mode    <= MODE_ABOVE;
            seg_reg <= SEG_W'(n_used);
          end else begin
            mode    <= MODE_INSIDE;
            seg_reg <= SEG_W'(hit);
          end
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          cnt <= '0;
          if (mode == MODE_INSIDE && dx > 0) begin
            base    <= y0;
            neg     <= dy[LANE_W];
            mcand   <= dy_mag[LANE_W-1:0];
            divisor <= dx[LANE_W-1:0];
            prod    <= {{LANE_W{1'b0}}, x_off[LANE_W-1:0]};
            state   <= ST_MUL;
          end else begin
            neg  <= 1'b0;
            prod <= '0;
            case (mode)
              MODE_BELOW: base <= y_lane[0];
              MODE_ABOVE: base <= y_last;
              default:    base <= yk;
            endcase
            state <= ST_DONE;
          end
        end
        ST_MUL: begin
          // add the multiplicand under the low bit, shift the product right;
          // the step count wraps to zero for the division
          prod <= {mul_sum, prod[LANE_W-1:1]};
          cnt  <= cnt + CNT_W'(1);
          if (cnt == LAST_STEP) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // shift in one dividend bit, subtract if it fits, shift in the quotient bit
          prod <= {div_rem[LANE_W-1:0], prod[LANE_W-2:0], div_ge};
          cnt  <= cnt + CNT_W'(1);
          if (cnt == LAST_STEP) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || result.ready) begin
            out_valid   <= 1'b1;
            out_degree  <= r_clamped;
            out_segment <= seg_reg;
            out_invalid <= bad_reg;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign sample.ready         = (state == ST_IDLE);
  assign result.valid         = out_valid;
  assign result.degree        = out_degree;
  assign result.segment       = out_segment;
  assign result.table_invalid = out_invalid;

endmodule
